// ----- hdl/itoaf_pkg.sv -----
`timescale 1ns / 1ps

package itoaf_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned MaxWidth   = 32;
  localparam int unsigned DigitSlots = 32;

  localparam int unsigned CntW  = $clog2(DigitSlots + 1);
  localparam int unsigned AddrW = $clog2(DigitSlots);
  localparam int unsigned WidW  = 6;
  localparam int unsigned InW   = 48;

  // reciprocal of ten: q = (v * RecipTen) >> RecipShift, exact for 32-bit v
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_SPACE = 2'd2,
    SIGN_MINUS = 2'd3
  } sign_e;

  typedef enum logic [2:0] {
    EMIT_LEAD  = 3'd0,
    EMIT_SIGN  = 3'd1,
    EMIT_ZERO  = 3'd2,
    EMIT_DIGIT = 3'd3,
    EMIT_TRAIL = 3'd4
  } emit_e;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  mul;
    logic  step;
    logic  setup;
    logic  emit;
    emit_e kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic next_zero;
    logic is_dec;
    logic left;
    logic zpad;
    logic has_sign;
    logic pad_zero;
    logic pad_one;
    logic cnt_one;
    logic slot_free;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ChUpA : ChLowA;
    if (d > 4'd9) begin
      return base + {4'd0, d} - 8'd10;
    end
    return ChZero + {4'd0, d};
  endfunction

  function automatic logic [7:0] sign_char(input sign_e s);
    logic [7:0] c;
    case (s)
      SIGN_PLUS:  c = ChPlus;
      SIGN_SPACE: c = ChSpace;
      SIGN_MINUS: c = ChMinus;
      default:    c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/itoaf_ctrl.sv -----
`timescale 1ns / 1ps

module itoaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itoaf_pkg::sts_t     sts_i,
  output itoaf_pkg::cmd_t     cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL    = 9'b000000010,
    ST_STEP   = 9'b000000100,
    ST_SETUP  = 9'b000001000,
    ST_LEAD   = 9'b000010000,
    ST_SIGN   = 9'b000100000,
    ST_ZPAD   = 9'b001000000,
    ST_DIGITS = 9'b010000000,
    ST_TRAIL  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // sequence extraction, then padding, sign, digits and trailing pad
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = itoaf_pkg::EMIT_LEAD;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.next_zero) begin
          state_d = ST_SETUP;
        end else if (sts_i.is_dec) begin
          state_d = ST_MUL;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_LEAD;
      end
      ST_LEAD: begin
        if (!sts_i.left && !sts_i.zpad && !sts_i.pad_zero) begin
          cmd_o.kind = itoaf_pkg::EMIT_LEAD;
          if (sts_i.slot_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.pad_one) state_d = ST_SIGN;
          end
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (sts_i.has_sign) begin
          cmd_o.kind = itoaf_pkg::EMIT_SIGN;
          if (sts_i.slot_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_ZPAD;
          end
        end else begin
          state_d = ST_ZPAD;
        end
      end
      ST_ZPAD: begin
        if (!sts_i.left && !sts_i.pad_zero) begin
          cmd_o.kind = itoaf_pkg::EMIT_ZERO;
          if (sts_i.slot_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.pad_one) state_d = ST_DIGITS;
          end
        end else begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        cmd_o.kind = itoaf_pkg::EMIT_DIGIT;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.cnt_one) state_d = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        if (!sts_i.pad_zero) begin
          cmd_o.kind = itoaf_pkg::EMIT_TRAIL;
          if (sts_i.slot_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.pad_one) state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // never push a character into an occupied output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.slot_free)
    else $error("character issued while output register is full");

  // a field started from idle leads into extraction on the next cycle
  a_load_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL)
    else $error("transaction accepted without starting extraction");

  // exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

// ----- hdl/itoaf_dp.sv -----
`timescale 1ns / 1ps

module itoaf_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [itoaf_pkg::InW-1:0]    in_data_i,
  input  itoaf_pkg::cmd_t              cmd_i,
  output itoaf_pkg::sts_t              sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_char_o,
  output logic                         out_last_o
);

  localparam int unsigned VB = itoaf_pkg::ValueBits;
  localparam int unsigned CW = itoaf_pkg::CntW;
  localparam int unsigned AW = itoaf_pkg::AddrW;
  localparam int unsigned WW = itoaf_pkg::WidW;

  logic [VB-1:0]          work_q;
  logic [2*VB-1:0]        prod_q;
  logic [CW-1:0]          cnt_q;
  logic [WW-1:0]          pad_q;
  logic [WW-1:0]          width_q;
  itoaf_pkg::base_e       base_q;
  itoaf_pkg::sign_e       sign_q;
  logic                   left_q, zpad_q, upper_q;
  logic [3:0]             mem [itoaf_pkg::DigitSlots];
  logic [3:0]             rd_q;
  logic                   out_valid_q, out_last_q;
  logic [7:0]             out_char_q;

  logic [WW-1:0]          in_width;
  logic [VB-1:0]          quot, quot_x10, rem_full, work_next;
  logic [3:0]             digit;
  logic [WW:0]            used;
  logic [WW-1:0]          pad_d;
  logic [CW-1:0]          rd_cnt;
  logic [AW-1:0]          rd_addr;
  logic                   emit_digit;
  logic [7:0]             char_d;
  logic                   last_d;

  // saturate the requested width
  always_comb begin
    in_width = in_data_i[VB+7:VB+2];
    if (in_width > WW'(itoaf_pkg::MaxWidth)) in_width = WW'(itoaf_pkg::MaxWidth);
  end

  // one digit per step: shift for power-of-two radix, reciprocal for ten
  always_comb begin
    quot     = VB'(prod_q[2*VB-1:itoaf_pkg::RecipShift]);
    quot_x10 = (quot << 3) + (quot << 1);
    rem_full = work_q - quot_x10;
    case (base_q)
      itoaf_pkg::BASE_BIN: begin
        digit     = {3'd0, work_q[0]};
        work_next = work_q >> 1;
      end
      itoaf_pkg::BASE_OCT: begin
        digit     = {1'b0, work_q[2:0]};
        work_next = work_q >> 3;
      end
      itoaf_pkg::BASE_DEC: begin
        digit     = rem_full[3:0];
        work_next = quot;
      end
      default: begin
        digit     = work_q[3:0];
        work_next = work_q >> 4;
      end
    endcase
  end

  // pad length from width, digit count and sign
  always_comb begin
    used  = (WW+1)'(cnt_q) + (WW+1)'(sign_q != itoaf_pkg::SIGN_NONE);
    pad_d = ({1'b0, width_q} > used) ? WW'({1'b0, width_q} - used) : '0;
  end

  // input fields and extraction registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q  <= in_data_i[VB-1:0];
      base_q  <= itoaf_pkg::base_e'(in_data_i[VB+1:VB]);
      width_q <= in_width;
      left_q  <= in_data_i[VB+8];
      zpad_q  <= in_data_i[VB+9];
      sign_q  <= itoaf_pkg::sign_e'(in_data_i[VB+11:VB+10]);
      upper_q <= in_data_i[VB+12];
    end else if (cmd_i.step) begin
      work_q <= work_next;
    end
    if (cmd_i.mul) begin
      prod_q <= (2*VB)'(work_q) * (2*VB)'(itoaf_pkg::RecipTen);
    end
  end

  // digit count and pad counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pad_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step && cnt_q < CW'(itoaf_pkg::DigitSlots)) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (emit_digit) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.setup) begin
        pad_q <= pad_d;
      end else if (cmd_i.emit && !emit_digit && cmd_i.kind != itoaf_pkg::EMIT_SIGN) begin
        pad_q <= pad_q - WW'(1);
      end
    end
  end

  // read one ahead so the next digit is ready when this one leaves
  assign emit_digit = cmd_i.emit && (cmd_i.kind == itoaf_pkg::EMIT_DIGIT);
  assign rd_cnt     = emit_digit ? cnt_q - CW'(2) : cnt_q - CW'(1);
  assign rd_addr    = rd_cnt[AW-1:0];

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cnt_q < CW'(itoaf_pkg::DigitSlots)) begin
      mem[cnt_q[AW-1:0]] <= digit;
    end
    rd_q <= mem[rd_addr];
  end

  // select the outgoing character
  always_comb begin
    case (cmd_i.kind)
      itoaf_pkg::EMIT_SIGN:  char_d = itoaf_pkg::sign_char(sign_q);
      itoaf_pkg::EMIT_ZERO:  char_d = itoaf_pkg::ChZero;
      itoaf_pkg::EMIT_DIGIT: char_d = itoaf_pkg::digit_char(rd_q, upper_q);
      default:               char_d = itoaf_pkg::ChSpace;
    endcase
    last_d = (emit_digit && cnt_q == CW'(1) && pad_q == '0) ||
             (cmd_i.kind == itoaf_pkg::EMIT_TRAIL && pad_q == WW'(1));
  end

  // output register: load on emit, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= char_d;
      out_last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  assign sts_o.next_zero = (work_next == '0);
  assign sts_o.is_dec    = (base_q == itoaf_pkg::BASE_DEC);
  assign sts_o.left      = left_q;
  assign sts_o.zpad      = zpad_q;
  assign sts_o.has_sign  = (sign_q != itoaf_pkg::SIGN_NONE);
  assign sts_o.pad_zero  = (pad_q == '0);
  assign sts_o.pad_one   = (pad_q == WW'(1));
  assign sts_o.cnt_one   = (cnt_q == CW'(1));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(itoaf_pkg::DigitSlots))
    else $error("digit count beyond store depth");

  a_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q <= WW'(itoaf_pkg::MaxWidth))
    else $error("pad count beyond maximum width");

  a_digit_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_digit |-> cnt_q != '0)
    else $error("digit issued from an empty store");

endmodule

// ----- hdl/integer_to_ascii_formatter_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid tready tdata[47:0]       one integer field to format
// m_axis    out  tvalid tready tdata[7:0] tlast  one character, tlast on the final one
//
// One field at a time: s_axis_tready is high only while the controller is idle.
// Extraction: radix 2, 8, 16 pass the multiply state once, then take one digit per step;
// radix 10 repeats reciprocal multiply, then remainder, for each digit; a setup state follows.
// Characters leave one per cycle while m_axis_tready is high; an empty lead pad, sign,
// zero pad or trailing pad phase still passes through its own controller state.
// A low m_axis_tready holds the sequencer; reset is asynchronous, active low, to idle.

module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // magnitude[31:0], base_code[33:32], field_width[39:34], left_align[40],
  // zero_pad[41], sign_code[43:42], upper_case[44], zero fill[47:45]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // char_out[7:0]
  output logic [7:0]  m_axis_tdata,
  // last_char
  output logic        m_axis_tlast
);

  itoaf_pkg::cmd_t cmd;
  itoaf_pkg::sts_t sts;

  itoaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itoaf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
